>>> hdl/epmc_pkg.sv
// Shared types and constants of the exact pattern match counter.
package epmc_pkg;

  // Widths of the fixed beat fields.
  localparam int BYTE_W      = 8;
  localparam int OUT_W       = 32;
  localparam int LEN_REG_W   = 6;
  localparam int LEN_CMP_W   = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // Pattern bytes carried by one pattern register, and bytes reachable by all of them.
  localparam int PAT_REG_BYTES = 8;
  localparam int PAT_WRITABLE  = 32;

  typedef logic [BYTE_W-1:0] byte_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LENGTH     = 3'd0,
    REG_PAT_0_7    = 3'd1,
    REG_PAT_8_15   = 3'd2,
    REG_PAT_16_23  = 3'd3,
    REG_PAT_24_31  = 3'd4
  } cfg_reg_t;

  // Per-beat control handed to the counter unit.
  typedef struct packed {
    logic step;
    logic hit;
    logic last;
  } tally_ctl_t;

endpackage

>>> hdl/epmc_in_if.sv
// Text input channel: one text byte per beat.
interface epmc_in_if import epmc_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t text_byte;
  logic  last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

>>> hdl/epmc_out_if.sv
// Result channel: one match result per beat.
interface epmc_out_if import epmc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             match_found;
  logic [OUT_W-1:0] match_start;
  logic [OUT_W-1:0] match_total;
  logic             text_done;

  modport source (output valid, output match_found, output match_start,
                  output match_total, output text_done, input ready);
  modport sink   (input valid, input match_found, input match_start,
                  input match_total, input text_done, output ready);
endinterface

>>> hdl/epmc_cfg_if.sv
// Configuration write channel: register index and write data per beat.
interface epmc_cfg_if import epmc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

>>> hdl/exact_pattern_match_counter.sv
// Top level of the exact pattern match counter: cell chain, pattern store and output stage.
//
//   channel  | direction | beat carries
//   ---------+-----------+------------------------------------------------
//   in_ch    | in        | text_byte, last_byte
//   out_ch   | out       | match_found, match_start, match_total, text_done
//   cfg_ch   | in        | addr (register index), data
//
// One text byte is taken per cycle while the output register is free; its result
// is in the output register in the next cycle, from the compare across the cells.
// Input is taken whenever the output register is empty or being drained, so a
// stalled result holds the input off only for as long as it waits.
// rst_n is synchronous: it empties the history, the counters and the output
// register and sets the pattern to length one, all bytes zero.
module exact_pattern_match_counter import epmc_pkg::*; #(
  parameter int MAX_PATTERN = 32,
  parameter int COUNT_WIDTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  epmc_in_if.sink   in_ch,
  epmc_out_if.source out_ch,
  epmc_cfg_if.sink  cfg_ch
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic                 in_fire;
  logic                 cfg_fire;
  logic                 in_rdy;
  logic [LEN_REG_W-1:0] len_r;
  byte_t                pat_r [MAX_PATTERN];
  logic [LEN_CMP_W-1:0] len_clip;
  byte_t                hist_byte [MAX_PATTERN];
  logic                 hist_vld  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit_vec;
  logic                 found;
  tally_ctl_t           tally_ctl;
  logic [OUT_W-1:0]     start_val;
  logic [OUT_W-1:0]     total_val;

  logic                 out_vld_r;
  logic                 found_r;
  logic [OUT_W-1:0]     start_r;
  logic [OUT_W-1:0]     total_r;
  logic                 done_r;

  // Handshakes: input flows whenever the output register can take a result.
  assign in_rdy       = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = in_rdy;
  assign in_fire      = in_ch.valid && in_rdy;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  // Pattern length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_REG_W'(1);
    end else if (cfg_fire && (cfg_ch.addr == REG_LENGTH)) begin
      len_r <= cfg_ch.data[LEN_REG_W-1:0];
    end
  end

  // Pattern bytes; positions past the four pattern registers stay zero.
  for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_pat
    if (p < PAT_WRITABLE) begin : g_wr
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          pat_r[p] <= '0;
        end else if (cfg_fire &&
                     (cfg_ch.addr == CFG_IDX_W'(int'(REG_PAT_0_7) + (p >> 3)))) begin
          pat_r[p] <= cfg_ch.data[(p & (PAT_REG_BYTES-1))*BYTE_W +: BYTE_W];
        end
      end
    end else begin : g_zero
      assign pat_r[p] = '0;
    end
  end

  // A length above the chain size acts as the full chain.
  assign len_clip = ({1'b0, len_r} > LEN_CMP_W'(MAX_PATTERN)) ?
                    LEN_CMP_W'(MAX_PATTERN) : {1'b0, len_r};

  // Cell chain: cell i holds the byte seen i beats ago and checks it against
  // the pattern byte that must sit at that distance from the end.
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic                 use_c;
    logic [LEN_CMP_W-1:0] pidx;
    byte_t                pat_c;
    byte_t                din_c;
    logic                 dvld_c;

    assign use_c  = LEN_CMP_W'(i) < len_clip;
    assign pidx   = len_clip - LEN_CMP_W'(i) - LEN_CMP_W'(1);
    assign pat_c  = use_c ? pat_r[pidx[IDX_W-1:0]] : '0;

    if (i == 0) begin : g_head
      assign din_c  = in_ch.text_byte;
      assign dvld_c = 1'b1;
    end else begin : g_link
      assign din_c  = hist_byte[i-1];
      assign dvld_c = hist_vld[i-1];
    end

    epmc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (in_fire),
      .clear    (in_ch.last_byte),
      .din      (din_c),
      .din_vld  (dvld_c),
      .in_use   (use_c),
      .pat      (pat_c),
      .dout     (hist_byte[i]),
      .dout_vld (hist_vld[i]),
      .hit      (hit_vec[i])
    );
  end

  // A match needs a nonzero length and every cell in use agreeing.
  assign found = (len_clip != '0) && (&hit_vec);

  assign tally_ctl.step = in_fire;
  assign tally_ctl.hit  = found;
  assign tally_ctl.last = in_ch.last_byte;

  epmc_tally #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tally (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (tally_ctl),
    .len   (len_clip),
    .start (start_val),
    .total (total_val)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Output register payload, loaded with each accepted beat's result.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      found_r <= found;
      start_r <= start_val;
      total_r <= total_val;
      done_r  <= in_ch.last_byte;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.match_found = found_r;
  assign out_ch.match_start = start_r;
  assign out_ch.match_total = total_r;
  assign out_ch.text_done   = done_r;

endmodule

>>> hdl/epmc_cell.sv
// One history cell: holds one recent text byte and compares the byte it takes in.
module epmc_cell import epmc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  logic  clear,
  input  byte_t din,
  input  logic  din_vld,
  input  logic  in_use,
  input  byte_t pat,
  output byte_t dout,
  output logic  dout_vld,
  output logic  hit
);

  byte_t byte_r;
  logic  vld_r;

  // The incoming byte is this cell's content after the shift, so compare it directly.
  assign hit = !in_use || (din_vld && (din == pat));

  // Valid bit marks a byte that belongs to the current text.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (step) begin
      vld_r <= din_vld && !clear;
    end
  end

  // Byte storage needs no reset; the valid bit guards it.
  always_ff @(posedge clk) begin
    if (step) begin
      byte_r <= din;
    end
  end

  assign dout     = byte_r;
  assign dout_vld = vld_r;

endmodule

>>> hdl/epmc_tally.sv
// Saturating position and match counters, with the per-beat start and total.
module epmc_tally import epmc_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tally_ctl_t           ctl,
  input  logic [LEN_CMP_W-1:0] len,
  output logic [OUT_W-1:0]     start,
  output logic [OUT_W-1:0]     total
);

  localparam logic [COUNT_WIDTH-1:0] SAT_MAX = '1;

  logic [COUNT_WIDTH-1:0] seen_r, seen_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] start_full;

  // Counts including the current byte, both stopping at all ones.
  always_comb begin
    seen_nxt = (seen_r != SAT_MAX) ? seen_r + 1'b1 : seen_r;
    cnt_nxt  = (ctl.hit && (cnt_r != SAT_MAX)) ? cnt_r + 1'b1 : cnt_r;
    start_full = ctl.hit ? (seen_nxt - COUNT_WIDTH'(len)) : '0;
  end

  // A last byte returns both counters to zero after its result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      cnt_r  <= '0;
    end else if (ctl.step) begin
      seen_r <= ctl.last ? '0 : seen_nxt;
      cnt_r  <= ctl.last ? '0 : cnt_nxt;
    end
  end

  // Fit the counter width to the result fields.
  if (COUNT_WIDTH >= OUT_W) begin : g_trunc
    assign start = start_full[OUT_W-1:0];
    assign total = cnt_nxt[OUT_W-1:0];
  end else begin : g_ext
    assign start = {{(OUT_W-COUNT_WIDTH){1'b0}}, start_full};
    assign total = {{(OUT_W-COUNT_WIDTH){1'b0}}, cnt_nxt};
  end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench of the exact pattern match counter: scoreboard, drivers and checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import epmc_pkg::*;

  localparam int              HIST_DEPTH     = 32;
  localparam longint unsigned COUNT_MAX      = 64'hFFFF_FFFF;
  localparam int              PAT_REGS       = PAT_WRITABLE / PAT_REG_BYTES;
  localparam int              RESET_CYCLES   = 10;
  localparam int              WATCHDOG_LIMIT = 2000;
  localparam int              DRAIN_CYCLES   = 8;
  localparam int              MAX_REPORTS    = 30;
  localparam int              RANDOM_PHASES  = 14;
  localparam int              PHASE_ITEMS    = 80;

  // Register indexes past the last pattern register; writes to them are dropped.
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = CFG_IDX_W'(int'(REG_PAT_24_31) + 1);

  // Length codes of the random phases, zero and the out-of-range codes among them.
  localparam logic [LEN_REG_W-1:0] PHASE_LENGTHS [RANDOM_PHASES] =
    '{6'd1, 6'd2, 6'd3, 6'd32, 6'd5, 6'd63, 6'd8, 6'd0, 6'd16, 6'd33, 6'd4, 6'd24, 6'd31, 6'd2};

  typedef struct packed {
    logic             found;
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] total;
    logic             done;
  } match_result_t;

  // Scoreboard: tracks the text history and pattern, and checks each result beat.
  class match_scoreboard;
    byte_t                history [HIST_DEPTH];
    byte_t                pattern [HIST_DEPTH];
    logic [LEN_REG_W-1:0] length_code;
    longint unsigned      text_pos;
    longint unsigned      text_hits;
    match_result_t        pending_results [$];
    int unsigned          failures;
    int unsigned          results_checked;
    int unsigned          hits_reported;
    int unsigned          texts_closed;

    function new();
      length_code = 1;
      foreach (pattern[i]) pattern[i] = '0;
      clear_text();
      failures        = 0;
      results_checked = 0;
      hits_reported   = 0;
      texts_closed    = 0;
    endfunction

    function void clear_text();
      foreach (history[i]) history[i] = '0;
      text_pos  = 0;
      text_hits = 0;
    endfunction

    task report(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("error: %s", msg);
    endtask

    // A register write lands in the length or in eight pattern bytes; other indexes are ignored.
    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      int pos;
      case (idx)
        REG_LENGTH: begin
          length_code = val[LEN_REG_W-1:0];
        end
        REG_PAT_0_7, REG_PAT_8_15, REG_PAT_16_23, REG_PAT_24_31: begin
          for (int i = 0; i < PAT_REG_BYTES; i++) begin
            pos = (idx - REG_PAT_0_7) * PAT_REG_BYTES + i;
            if (pos < HIST_DEPTH) pattern[pos] = val[i*BYTE_W +: BYTE_W];
          end
        end
        default: begin
        end
      endcase
    endfunction

    // Shift the byte in, compare the newest bytes with the pattern and queue the result.
    function void note_text_byte(byte_t b, logic fin);
      int unsigned   span;
      match_result_t r;
      span = (length_code > HIST_DEPTH) ? HIST_DEPTH : length_code;
      for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = b;
      if (text_pos < COUNT_MAX) text_pos++;
      r = '0;
      // A match needs a nonzero length and enough bytes of this text.
      r.found = (span != 0) && (text_pos >= span);
      for (int i = 0; i < span; i++) begin
        if (history[i] != pattern[span-1-i]) r.found = 1'b0;
      end
      if (r.found) begin
        r.start = OUT_W'(text_pos - span);
        if (text_hits < COUNT_MAX) text_hits++;
      end
      r.total = text_hits[OUT_W-1:0];
      r.done  = fin;
      pending_results.push_back(r);
      if (fin) clear_text();
    endfunction

    task check_result(match_result_t got);
      match_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with none pending: found=%0b start=%0d total=%0d done=%0b",
                         got.found, got.start, got.total, got.done));
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (got.found === 1'b1) hits_reported++;
      if (got.done === 1'b1) texts_closed++;
      if (got.found !== want.found)
        report($sformatf("result %0d: match_found %0b, want %0b",
                         results_checked, got.found, want.found));
      if (got.start !== want.start)
        report($sformatf("result %0d: match_start %0d, want %0d",
                         results_checked, got.start, want.start));
      if (got.total !== want.total)
        report($sformatf("result %0d: match_total %0d, want %0d",
                         results_checked, got.total, want.total));
      if (got.done !== want.done)
        report($sformatf("result %0d: text_done %0b, want %0b",
                         results_checked, got.done, want.done));
    endtask
  endclass

  logic clk;
  logic rst_n;

  epmc_in_if  in_ch();
  epmc_out_if out_ch();
  epmc_cfg_if cfg_ch();

  exact_pattern_match_counter #(
    .MAX_PATTERN(HIST_DEPTH),
    .COUNT_WIDTH(OUT_W)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  match_scoreboard board;
  bit              steady = 1'b0;
  int              stall_left = 0;
  int              idle_cycles = 0;
  int unsigned     bytes_sent;
  int unsigned     reg_writes;
  int unsigned     settings_used;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Gap length: mostly short, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side back-pressure.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 30) begin
      stall_left = pick_gap() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Beat monitor: feeds the scoreboard from every handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        board.apply_write(cfg_ch.addr, cfg_ch.data);
        reg_writes++;
      end
      if (in_ch.valid && in_ch.ready) board.note_text_byte(in_ch.text_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready)
        board.check_result('{out_ch.match_found, out_ch.match_start, out_ch.match_total,
                             out_ch.text_done});
    end
  end

  // Watchdog: the run ends if no beat moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a beat", idle_cycles);
      $display("exact_pattern_match_counter: mismatch");
      $finish;
    end
  end

  // Send one text byte; valid stays high when the next byte follows at once.
  task automatic send_text_byte(input byte_t b, input logic fin);
    int gap;
    gap = (steady || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.last_byte <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Write a spare index, the length code and all four pattern registers.
  task automatic load_pattern(input logic [LEN_REG_W-1:0] len_code,
                              input byte_t pat [HIST_DEPTH]);
    logic [CFG_DATA_W-1:0] word;
    word = {$urandom, $urandom};
    write_reg(FIRST_SPARE_REG + CFG_IDX_W'($urandom_range(0, 2)), word);
    word = {$urandom, $urandom};
    word[LEN_REG_W-1:0] = len_code;
    write_reg(REG_LENGTH, word);
    for (int r = 0; r < PAT_REGS; r++) begin
      for (int i = 0; i < PAT_REG_BYTES; i++) begin
        word[i*BYTE_W +: BYTE_W] = pat[r*PAT_REG_BYTES + i];
      end
      write_reg(CFG_IDX_W'(REG_PAT_0_7 + r), word);
    end
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Stop sending and wait until every queued result has come out.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending_results.size() != 0);
  endtask

  initial begin
    byte_t                pat [HIST_DEPTH];
    byte_t                alpha [3];
    logic [LEN_REG_W-1:0] len_code;
    int                   span;
    int                   text_len;
    int                   room;
    int                   pos;
    int                   cut;
    int unsigned          phase_start;

    board         = new();
    bytes_sent    = 0;
    reg_writes    = 0;
    settings_used = 1;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.text_byte  <= '0;
    in_ch.last_byte  <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.addr      <= '0;
    cfg_ch.data      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting is a single zero byte, so each zero byte matches.
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(8'h00, 1'b1);
    settle();

    // Overlapping occurrences of a three byte pattern.
    foreach (pat[i]) pat[i] = '0;
    pat[0] = 8'h41;
    pat[1] = 8'h42;
    pat[2] = 8'h41;
    load_pattern(6'd3, pat);
    send_text_byte(8'h41, 1'b0);
    send_text_byte(8'h42, 1'b0);
    send_text_byte(8'h41, 1'b0);
    send_text_byte(8'h42, 1'b0);
    send_text_byte(8'h41, 1'b1);
    settle();

    // The cleared history holds zeros, but a fresh text must not match before
    // it has as many bytes as the pattern.
    pat[0] = 8'h00;
    pat[1] = 8'h00;
    pat[2] = 8'hFF;
    load_pattern(6'd3, pat);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b1);
    settle();

    // A zero length never matches.
    load_pattern(6'd0, pat);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b1);
    settle();

    // Random phases: texts over a small alphabet with planted and broken copies.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      len_code = PHASE_LENGTHS[ph];
      span = (len_code > HIST_DEPTH) ? HIST_DEPTH : len_code;
      if (ph == 0) begin
        alpha[0] = 8'h00;
        alpha[1] = 8'hFF;
        alpha[2] = 8'h00;
      end else begin
        foreach (alpha[i]) alpha[i] = byte_t'($urandom);
      end
      foreach (pat[i]) pat[i] = (i < span) ? alpha[$urandom_range(0, 2)] : byte_t'($urandom);
      load_pattern(len_code, pat);
      steady = ($urandom_range(0, 3) == 0);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS) begin
        text_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 40);
        // The last text of a phase ends where the phase's byte budget runs out.
        room = PHASE_ITEMS - int'(bytes_sent - phase_start);
        if (text_len > room) text_len = room;
        pos = 0;
        while (pos < text_len) begin
          if (span != 0 && $urandom_range(0, 99) < 35) begin
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, span) : span;
            for (int k = 0; k < cut && pos < text_len; k++) begin
              send_text_byte(pat[k], pos == text_len - 1);
              pos++;
            end
          end else begin
            send_text_byte(($urandom_range(0, 3) == 0) ? byte_t'($urandom)
                                                       : alpha[$urandom_range(0, 2)],
                           pos == text_len - 1);
            pos++;
          end
        end
      end
      settle();
    end

    steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending_results.size() != 0)
      board.report($sformatf("%0d results never arrived", board.pending_results.size()));

    $display("Sent %0d text bytes in %0d texts under %0d pattern settings (%0d register writes).",
             bytes_sent, board.texts_closed, settings_used, reg_writes);
    $display("Checked %0d results, %0d of them matches; %0d failures.",
             board.results_checked, board.hits_reported, board.failures);
    if (board.failures == 0) begin
      $display("exact_pattern_match_counter: match");
    end else begin
      $display("exact_pattern_match_counter: mismatch");
    end
    $finish;
  end

endmodule

>>> exact_pattern_match_counter.f
hdl/epmc_pkg.sv
hdl/epmc_in_if.sv
hdl/epmc_out_if.sv
hdl/epmc_cfg_if.sv
hdl/epmc_cell.sv
hdl/epmc_tally.sv
hdl/exact_pattern_match_counter.sv
tb/sv/testbench.sv
